// ===== rtl/surround_to_stereo_downmix_top_assert.svh =====
// Assertion macros for the surround-to-stereo downmix block.
// Included by surround_to_stereo_downmix_top.sv; expects clk and rst_n in scope.
`ifndef SURROUND_TO_STEREO_DOWNMIX_TOP_ASSERT_SVH
`define SURROUND_TO_STEREO_DOWNMIX_TOP_ASSERT_SVH

`ifndef SYNTH
// Checked only out of reset
`define S2SD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included
`define S2SD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define S2SD_ASSERT(lbl, prop, msg)
`define S2SD_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== rtl/s2sd_pkg.sv =====
// Shared types, widths and coefficients of the surround-to-stereo downmix.
// No dependencies.
package s2sd_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int CHAN_W      = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 3;

  // Q16 coefficients, held as positive signed values
  localparam int COEF_W = 17;
  localparam logic signed [COEF_W-1:0] COEF_CENTER   = 17'sd46341;
  localparam logic signed [COEF_W-1:0] COEF_SIDE     = 17'sd57133;
  localparam logic signed [COEF_W-1:0] COEF_SIDE_INV = 17'sd32106;

  // Phase mix 3*cur + other carries two fraction bits
  localparam int MIX_W    = SAMPLE_BITS + 3;
  localparam int PROD_W   = MIX_W + COEF_W;
  localparam int CTR_W    = SAMPLE_BITS + COEF_W;
  localparam int ACC_W    = PROD_W + 2;
  localparam int ACC_SHIFT = 18;
  localparam int INT_W    = ACC_W - ACC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (ACC_SHIFT - 1);

  localparam int SAT_HI = (1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam int SAT_LO = -SAT_HI - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_MONO_MODE     = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MIX_STEREO,
    MIX_QUAD,
    MIX_FIVE
  } mix_mode_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t f0;
    sample_t f1;
    sample_t f2;
    sample_t f3;
    sample_t f4;
  } frame_t;

  // One result to compute: the frame and its neighbouring rear samples
  typedef struct packed {
    frame_t  frm;
    sample_t prev0;
    sample_t prev1;
    sample_t next0;
    sample_t next1;
    logic    last;
  } job_t;

  // Products registered between the two arithmetic stages
  typedef struct packed {
    sample_t                   fl;
    sample_t                   fr;
    logic signed [PROD_W-1:0]  la;
    logic signed [PROD_W-1:0]  lb;
    logic signed [PROD_W-1:0]  ra;
    logic signed [PROD_W-1:0]  rb;
    logic signed [CTR_W-1:0]   ctr;
    logic                      last;
  } prod_t;

  // Clamp a rounded value to the sample range
  function automatic sample_t sat_sample(input logic signed [INT_W-1:0] v);
    sample_t res;
    if (v > INT_W'(SAT_HI)) begin
      res = SAMPLE_BITS'(SAT_HI);
    end else if (v < INT_W'(SAT_LO)) begin
      res = SAMPLE_BITS'(SAT_LO);
    end else begin
      res = SAMPLE_BITS'(v);
    end
    return res;
  endfunction

endpackage

// ===== rtl/surround_to_stereo_downmix_top.sv =====
// Surround-to-stereo downmix: one multichannel frame in, stereo frames out.
// Depends on s2sd_pkg and surround_to_stereo_downmix_top_assert.svh.
//
// Usage: the block takes one frame per cycle while in_stall is low. A
// frame's stereo result needs the following frame (for the rear phase
// shift), so it is issued when that frame arrives, then passes a job
// register, a product register and the output register to out_valid. A
// frame flagged end_of_stream is also issued as its own result right after
// the held one; the second result of that pair follows the first on the
// single result path, so in_stall is high after such a frame until that
// result is issued, and for as long as the result path stays blocked. A
// lone end frame with no held frame does not stall the input. Without
// back-pressure the sustained rate is one frame per cycle. Configuration
// (channel_count at index 0, mono_mode at index 1) is always ready and must
// only be written while no frame is held or in flight.
`include "surround_to_stereo_downmix_top_assert.svh"

module surround_to_stereo_downmix_top
  import s2sd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // frame input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_front_left,
  input  logic signed [SAMPLE_BITS-1:0] in_front_right,
  input  logic signed [SAMPLE_BITS-1:0] in_third_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_fourth_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_fifth_channel,
  input  logic signed [SAMPLE_BITS-1:0] in_sixth_channel,
  input  logic                  in_end_of_stream,
  // stereo output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left,
  output logic signed [SAMPLE_BITS-1:0] out_right,
  output logic                  out_last_of_run,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration
  logic [CHAN_W-1:0] chan_cnt_r;
  logic              mono_r;

  // Held frame and stream state
  frame_t  held_r;
  logic    held_valid_r;
  logic    held_eos_r;
  logic    have_prev_r;
  sample_t prev0_r;
  sample_t prev1_r;

  // Pipeline registers
  job_t    job_r;
  job_t    job_nxt;
  logic    job_v_r;
  logic    job_load;
  prod_t   prod_r;
  prod_t   prod_nxt;
  logic    prod_v_r;
  sample_t out_left_r;
  sample_t out_right_r;
  sample_t left_nxt;
  sample_t right_nxt;
  logic    out_last_r;
  logic    out_v_r;

  // Handshake
  logic    out_adv;
  logic    prod_adv;
  logic    job_ok;
  logic    flush_go;
  logic    in_acc;
  frame_t  cur;

  assign cfg_ready = 1'b1;

  assign out_adv  = !out_v_r || !out_stall;
  assign prod_adv = !prod_v_r || out_adv;
  assign job_ok   = !job_v_r || prod_adv;
  assign flush_go = held_eos_r && job_ok;
  assign in_stall = held_eos_r || !job_ok;
  assign in_acc   = in_valid && !in_stall;

  // LFE is dropped; it only rides along on the input port
  assign cur = '{f0: in_front_left, f1: in_front_right, f2: in_third_channel,
                 f3: in_fourth_channel, f4: in_fifth_channel};

  // Issue a job: flush of a held end frame, held frame, or lone end frame
  always_comb begin
    job_load = 1'b0;
    job_nxt  = job_r;
    if (flush_go) begin
      job_load = 1'b1;
      job_nxt  = '{frm: held_r,
                   prev0: have_prev_r ? prev0_r : held_r.f2,
                   prev1: have_prev_r ? prev1_r : held_r.f3,
                   next0: held_r.f2, next1: held_r.f3, last: 1'b1};
    end else if (in_acc && held_valid_r) begin
      job_load = 1'b1;
      job_nxt  = '{frm: held_r,
                   prev0: have_prev_r ? prev0_r : held_r.f2,
                   prev1: have_prev_r ? prev1_r : held_r.f3,
                   next0: cur.f2, next1: cur.f3, last: 1'b0};
    end else if (in_acc && in_end_of_stream) begin
      job_load = 1'b1;
      job_nxt  = '{frm: cur, prev0: cur.f2, prev1: cur.f3,
                   next0: cur.f2, next1: cur.f3, last: 1'b1};
    end
  end

  // Stage one: phase mixes and coefficient products
  always_comb begin
    mix_mode_t               mode;
    logic signed [MIX_W-1:0] mix_la;
    logic signed [MIX_W-1:0] mix_lb;
    logic signed [MIX_W-1:0] mix_ra;
    logic signed [MIX_W-1:0] mix_rb;
    logic signed [COEF_W-1:0] c_la;
    logic signed [COEF_W-1:0] c_lb;
    logic signed [COEF_W-1:0] c_ra;
    logic signed [COEF_W-1:0] c_rb;
    sample_t                  ctr_s;

    case (chan_cnt_r) inside
      3'd4:         mode = MIX_QUAD;
      [3'd5:3'd7]:  mode = MIX_FIVE;
      default:      mode = MIX_STEREO;
    endcase

    mix_la = (MIX_W'(job_r.frm.f2) <<< 1) + MIX_W'(job_r.frm.f2) + MIX_W'(job_r.next0);
    mix_ra = (MIX_W'(job_r.frm.f2) <<< 1) + MIX_W'(job_r.frm.f2) + MIX_W'(job_r.prev0);
    mix_lb = (MIX_W'(job_r.frm.f3) <<< 1) + MIX_W'(job_r.frm.f3) + MIX_W'(job_r.next1);
    mix_rb = (MIX_W'(job_r.frm.f3) <<< 1) + MIX_W'(job_r.frm.f3) + MIX_W'(job_r.prev1);

    case (mode)
      MIX_FIVE: begin
        c_la  = COEF_SIDE;
        c_lb  = COEF_SIDE_INV;
        c_ra  = COEF_SIDE_INV;
        c_rb  = COEF_SIDE;
        ctr_s = job_r.frm.f4;
      end
      MIX_QUAD: begin
        c_la  = COEF_CENTER;
        c_lb  = '0;
        c_ra  = COEF_CENTER;
        c_rb  = '0;
        ctr_s = job_r.frm.f3;
      end
      default: begin
        c_la  = '0;
        c_lb  = '0;
        c_ra  = '0;
        c_rb  = '0;
        ctr_s = '0;
      end
    endcase

    prod_nxt.fl   = job_r.frm.f0;
    prod_nxt.fr   = job_r.frm.f1;
    prod_nxt.la   = PROD_W'(mix_la) * PROD_W'(c_la);
    prod_nxt.lb   = PROD_W'(mix_lb) * PROD_W'(c_lb);
    prod_nxt.ra   = PROD_W'(mix_ra) * PROD_W'(c_ra);
    prod_nxt.rb   = PROD_W'(mix_rb) * PROD_W'(c_rb);
    prod_nxt.ctr  = CTR_W'(ctr_s) * CTR_W'(COEF_CENTER);
    prod_nxt.last = job_r.last;
  end

  // Stage two: accumulate in Q18, round once, optional mono, saturate
  always_comb begin
    logic signed [ACC_W-1:0] acc_l;
    logic signed [ACC_W-1:0] acc_r;
    logic signed [ACC_W-1:0] ctr_q;
    logic signed [ACC_W-1:0] rnd_l;
    logic signed [ACC_W-1:0] rnd_r;
    logic signed [INT_W-1:0] li;
    logic signed [INT_W-1:0] ri;
    logic signed [INT_W:0]   sum_lr;
    logic signed [INT_W:0]   sum_adj;
    logic signed [INT_W-1:0] avg;

    ctr_q = ACC_W'(prod_r.ctr) <<< 2;
    acc_l = (ACC_W'(prod_r.fl) <<< ACC_SHIFT) + ACC_W'(prod_r.la) + ACC_W'(prod_r.lb) + ctr_q;
    acc_r = (ACC_W'(prod_r.fr) <<< ACC_SHIFT) + ACC_W'(prod_r.ra) + ACC_W'(prod_r.rb) + ctr_q;
    rnd_l = (acc_l + ROUND_HALF) >>> ACC_SHIFT;
    rnd_r = (acc_r + ROUND_HALF) >>> ACC_SHIFT;
    li    = rnd_l[INT_W-1:0];
    ri    = rnd_r[INT_W-1:0];

    // Halve the sum, truncating toward zero
    sum_lr  = (INT_W+1)'(li) + (INT_W+1)'(ri);
    sum_adj = sum_lr + (INT_W+1)'(sum_lr[INT_W]);
    avg     = INT_W'(sum_adj >>> 1);

    if (mono_r) begin
      left_nxt  = sat_sample(avg);
      right_nxt = sat_sample(avg);
    end else begin
      left_nxt  = sat_sample(li);
      right_nxt = sat_sample(ri);
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r   <= CHAN_W'(2);
      mono_r       <= 1'b0;
      held_valid_r <= 1'b0;
      held_eos_r   <= 1'b0;
      have_prev_r  <= 1'b0;
      job_v_r      <= 1'b0;
      prod_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CHANNEL_COUNT: chan_cnt_r <= cfg_data[CHAN_W-1:0];
          CFG_MONO_MODE:     mono_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (job_ok) begin
        job_v_r <= job_load;
      end
      if (prod_adv) begin
        prod_v_r <= job_v_r;
      end
      if (out_adv) begin
        out_v_r <= prod_v_r;
      end
      // Close the stream after the flush, or take the new frame
      if (flush_go) begin
        held_valid_r <= 1'b0;
        held_eos_r   <= 1'b0;
        have_prev_r  <= 1'b0;
      end else if (in_acc) begin
        have_prev_r <= held_valid_r;
        if (!held_valid_r && in_end_of_stream) begin
          held_valid_r <= 1'b0;
          held_eos_r   <= 1'b0;
        end else begin
          held_valid_r <= 1'b1;
          held_eos_r   <= in_end_of_stream;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      held_r <= cur;
      if (held_valid_r) begin
        prev0_r <= held_r.f2;
        prev1_r <= held_r.f3;
      end
    end
    if (job_ok) begin
      job_r <= job_nxt;
    end
    if (prod_adv) begin
      prod_r <= prod_nxt;
    end
    if (out_adv) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_last_r  <= prod_r.last;
    end
  end

  assign out_valid       = out_v_r;
  assign out_left        = out_left_r;
  assign out_right       = out_right_r;
  assign out_last_of_run = out_last_r;

  // Checks
  `S2SD_ASSERT(a_eos_needs_held, held_eos_r |-> held_valid_r, "end frame with no held frame")
  `S2SD_ASSERT(a_prev_needs_held, have_prev_r |-> held_valid_r, "stale previous rear")
  `S2SD_ASSERT(a_eos_from_input, $rose(held_eos_r) |-> $past(in_acc && in_end_of_stream), "stray end")
  `S2SD_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "output valid after reset")

endmodule
